[sv/bkit_pkg.sv]
// ----------------------------------------------------------------------------
// bkit_pkg
// Codes and transfer types shared by the banked key interning table.
// ----------------------------------------------------------------------------
package bkit_pkg;

	localparam logic [1:0] FUNC_ADD   = 2'd0;
	localparam logic [1:0] FUNC_GET   = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	localparam logic [2:0] ST_ADDED     = 3'd0;
	localparam logic [2:0] ST_PRESENT   = 3'd1;
	localparam logic [2:0] ST_FULL      = 3'd2;
	localparam logic [2:0] ST_BAD_TABLE = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_CLEARED   = 3'd5;

	typedef struct packed {
		logic [1:0]  func;
		logic [2:0]  table_sel;
		logic [63:0] key;
		logic [5:0]  position;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  slot;
		logic [63:0] stored_key;
	} rsp_t;

	typedef struct packed {
		logic        valid;
		logic        done;
		logic [1:0]  func;
		logic [2:0]  table_sel;
		logic [63:0] key;
		logic [5:0]  position;
		logic [2:0]  status;
		logic [5:0]  slot;
		logic [63:0] stored_key;
	} tok_t;

endpackage

[sv/bkit_cell.sv]
// ----------------------------------------------------------------------------
// bkit_cell
// One slot of every table; compares, appends or reads as the token passes.
// ----------------------------------------------------------------------------
module bkit_cell import bkit_pkg::*; #(
	parameter int IDX      = 0,
	parameter int ENTRIES  = 64,
	parameter int TABLES   = 7,
	parameter int KEY_BITS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tok_t                         tok_in,
	input  logic [$clog2(ENTRIES+1)-1:0] fill_in,
	output tok_t                         tok_out,
	output logic [$clog2(ENTRIES+1)-1:0] fill_out
);

	localparam int FW = $clog2(ENTRIES + 1);
	localparam int TW = (TABLES > 1) ? $clog2(TABLES) : 1;
	localparam int CW = (FW > 6) ? FW : 6;

	logic [KEY_BITS-1:0] store_q [TABLES];
	logic [TW-1:0]       tsel;
	logic [KEY_BITS-1:0] rd;
	logic [FW-1:0]       idx;
	logic                below_fill;
	logic                wr;
	tok_t                tok_nxt;
	tok_t                tok_q;
	logic [FW-1:0]       fill_q;

	assign tsel       = TW'(tok_in.table_sel);
	assign rd         = store_q[tsel];
	assign idx        = FW'(IDX);
	assign below_fill = idx < fill_in;
	assign wr         = tok_in.valid && !tok_in.done && tok_in.func == FUNC_ADD &&
		!below_fill && idx == fill_in;

	always_comb begin
		tok_nxt = tok_in;
		if (tok_in.valid && !tok_in.done) begin
			unique case (tok_in.func)
				FUNC_ADD: begin
					if (below_fill && rd == tok_in.key[KEY_BITS-1:0]) begin
						tok_nxt.done   = 1'b1;
						tok_nxt.status = ST_PRESENT;
						tok_nxt.slot   = 6'(IDX);
					end else if (wr) begin
						tok_nxt.done   = 1'b1;
						tok_nxt.status = ST_ADDED;
						tok_nxt.slot   = 6'(IDX);
					end
				end
				FUNC_GET: begin
					if (CW'(IDX) == CW'(tok_in.position) && below_fill) begin
						tok_nxt.done       = 1'b1;
						tok_nxt.status     = ST_PRESENT;
						tok_nxt.stored_key = 64'(rd);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			store_q[tsel] <= tok_in.key[KEY_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			fill_q <= '0;
		end else begin
			tok_q  <= tok_nxt;
			fill_q <= fill_in;
		end
	end

	assign tok_out  = tok_q;
	assign fill_out = fill_q;

endmodule

[sv/banked_key_interning_table.sv]
// ----------------------------------------------------------------------------
// banked_key_interning_table
// Interning tables mapping keys to dense slots, searched by a chain of cells.
//
//   channel  dir  payload  handshake
//   req      in   req_t    req_valid / req_stall
//   rsp      out  rsp_t    rsp_valid / rsp_stall
//
// Add and get run a token through ENTRIES cells, one cell per cycle; no new
// request is taken until its result leaves. Clear, bad table and unused codes
// answer in the cycle after they are taken. Reset empties every table at once;
// no clearing pass. A stalled result holds the chain output until it moves on.
// ----------------------------------------------------------------------------
module banked_key_interning_table import bkit_pkg::*; #(
	parameter int ENTRIES  = 64,
	parameter int TABLES   = 7,
	parameter int KEY_BITS = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int          FW       = $clog2(ENTRIES + 1);
	localparam int          TW       = (TABLES > 1) ? $clog2(TABLES) : 1;
	localparam logic [63:0] KEY_MASK = {64{1'b1}} >> (64 - KEY_BITS);

	tok_t          tok_c  [ENTRIES+1];
	logic [FW-1:0] fill_c [ENTRIES+1];
	logic [FW-1:0] fill_q [TABLES];

	logic    busy_q;
	logic    pend_valid_q;
	rsp_t    pend_q;
	logic    rsp_valid_q;
	rsp_t    rsp_q;
	logic    take;
	logic    out_free;
	logic    good_tbl;
	logic    chain_go;
	rsp_t    imm;
	tok_t    tail;
	logic [TW-1:0] req_t_idx;
	logic [TW-1:0] tail_idx;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = busy_q || !out_free;
	assign take      = req_valid && !req_stall;
	assign good_tbl  = 32'(req.table_sel) < 32'(TABLES);
	assign chain_go  = take && good_tbl && (req.func == FUNC_ADD || req.func == FUNC_GET);
	assign req_t_idx = TW'(req.table_sel);
	assign tail      = tok_c[ENTRIES];
	assign tail_idx  = TW'(tail.table_sel);

	always_comb begin
		imm = '0;
		unique case (req.func) inside
			FUNC_CLEAR: imm.status = ST_CLEARED;
			FUNC_ADD, FUNC_GET: imm.status = ST_BAD_TABLE;
			default: imm.status = ST_NOT_FOUND;
		endcase
	end

	always_comb begin
		tok_c[0]            = '0;
		tok_c[0].valid      = chain_go;
		tok_c[0].func       = req.func;
		tok_c[0].table_sel  = req.table_sel;
		tok_c[0].key        = req.key & KEY_MASK;
		tok_c[0].position   = req.position;
		fill_c[0]           = fill_q[req_t_idx];
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		bkit_cell #(
			.IDX      (i),
			.ENTRIES  (ENTRIES),
			.TABLES   (TABLES),
			.KEY_BITS (KEY_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.tok_in   (tok_c[i]),
			.fill_in  (fill_c[i]),
			.tok_out  (tok_c[i+1]),
			.fill_out (fill_c[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			for (int t = 0; t < TABLES; t++) begin
				fill_q[t] <= '0;
			end
		end else begin
			if ((take && !chain_go) || (pend_valid_q && out_free)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (chain_go) begin
				busy_q <= 1'b1;
			end else if (take && req.func == FUNC_CLEAR) begin
				for (int t = 0; t < TABLES; t++) begin
					fill_q[t] <= '0;
				end
			end
			if (tail.valid) begin
				pend_valid_q <= 1'b1;
				if (tail.done && tail.status == ST_ADDED) begin
					fill_q[tail_idx] <= fill_c[ENTRIES] + FW'(1);
				end
			end
			if (pend_valid_q && out_free) begin
				pend_valid_q <= 1'b0;
				busy_q       <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tail.valid) begin
			if (tail.done) begin
				pend_q.status     <= tail.status;
				pend_q.slot       <= tail.slot;
				pend_q.stored_key <= tail.stored_key;
			end else begin
				pend_q.status     <= (tail.func == FUNC_ADD) ? ST_FULL : ST_NOT_FOUND;
				pend_q.slot       <= '0;
				pend_q.stored_key <= '0;
			end
		end
		if (pend_valid_q && out_free) begin
			rsp_q <= pend_q;
		end else if (take && !chain_go) begin
			rsp_q <= imm;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/bkit_chk.sv]
// ----------------------------------------------------------------------------
// bkit_chk
// Port-level checks for the banked key interning table.
// ----------------------------------------------------------------------------
module bkit_chk import bkit_pkg::*; #(
	parameter int ENTRIES  = 64,
	parameter int TABLES   = 7,
	parameter int KEY_BITS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp
);

	localparam int DEPTH = ENTRIES * KEY_BITS;

	logic req_xfer;
	logic long_op;

	assign req_xfer = req_valid && !req_stall;
	assign long_op  = (req.func == FUNC_ADD || req.func == FUNC_GET) &&
		32'(req.table_sel) < 32'(TABLES) && DEPTH > 0;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && long_op |=> req_stall)
		else $error("request taken while a search runs");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer && req.func == FUNC_CLEAR |=> rsp_valid && rsp.status == ST_CLEARED)
		else $error("clear not answered next cycle");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_PRESENT |-> rsp.stored_key == '0 &&
		(rsp.status == ST_ADDED || rsp.slot == '0))
		else $error("unused response field not zero");

endmodule

bind banked_key_interning_table bkit_chk #(
	.ENTRIES  (ENTRIES),
	.TABLES   (TABLES),
	.KEY_BITS (KEY_BITS)
) u_bkit_chk (.*);

[tb/banked_key_interning_table_tb.sv]
// ----------------------------------------------------------------------------
// banked_key_interning_table_tb
// Self-checking bench for the banked key interning table. Requests are built
// in advance into a pending queue. A bursty driver sends them. A predictor
// holding its own copy of every table computes the response for each accepted
// transfer. A monitor checks each response, in order, against that prediction
// while the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module banked_key_interning_table_tb import bkit_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES    = 64;
	localparam int TABLES     = 7;
	localparam int KEY_BITS   = 64;
	localparam int CLK_PERIOD = 8;
	localparam int RAND_ITEMS = 400;
	localparam int CYCLE_LIMIT = 500000;

	localparam logic [1:0] FUNC_SPARE = 2'd3;
	localparam logic [2:0] SEL_BAD    = 3'd7;

	typedef struct {
		req_t req;
		bit   drain;
	} pend_t;

	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	pend_t pending_req[$];
	rsp_t  expected_rsp[$];
	rsp_t  observed_rsp[$];

	logic [63:0] model_keys [TABLES][ENTRIES];
	int          model_fill [TABLES];
	logic [63:0] gen_keys   [TABLES][ENTRIES];
	int          gen_fill   [TABLES];

	int n_queued;
	int n_sent;
	int n_checked;
	int mismatch_count;
	int status_seen [8];
	int cycle_count;
	int burst_left;
	int gap_left;
	int mode_left;
	int stall_phase;
	stall_mode_t stall_mode;

	banked_key_interning_table #(
		.ENTRIES(ENTRIES),
		.TABLES(TABLES),
		.KEY_BITS(KEY_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic rsp_t intern_predict(req_t r);
		rsp_t o;
		int t;
		int n;
		bit hit;
		o = '0;
		t = int'(r.table_sel);
		hit = 1'b0;
		if (r.func == FUNC_CLEAR) begin
			for (int i = 0; i < TABLES; i++)
				model_fill[i] = 0;
			o.status = ST_CLEARED;
		end else if (r.func == FUNC_SPARE) begin
			o.status = ST_NOT_FOUND;
		end else if (t >= TABLES) begin
			o.status = ST_BAD_TABLE;
		end else if (r.func == FUNC_ADD) begin
			n = model_fill[t];
			for (int i = 0; i < n && !hit; i++) begin
				if (model_keys[t][i] == r.key) begin
					o.status = ST_PRESENT;
					o.slot   = 6'(i);
					hit      = 1'b1;
				end
			end
			if (!hit) begin
				if (n >= ENTRIES) begin
					o.status = ST_FULL;
				end else begin
					model_keys[t][n] = r.key;
					model_fill[t]    = n + 1;
					o.status         = ST_ADDED;
					o.slot           = 6'(n);
				end
			end
		end else if (int'(r.position) >= model_fill[t]) begin
			o.status = ST_NOT_FOUND;
		end else begin
			o.status     = ST_PRESENT;
			o.stored_key = model_keys[t][r.position];
		end
		return o;
	endfunction

	function automatic logic [63:0] rand_key();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] pick_key(int t);
		if (t < TABLES && gen_fill[t] > 0 && $urandom_range(0, 1) == 1)
			return gen_keys[t][$urandom_range(0, gen_fill[t] - 1)];
		return rand_key();
	endfunction

	function automatic logic [5:0] pick_pos(int t);
		int p;
		if (t < TABLES && $urandom_range(0, 9) < 7) begin
			p = $urandom_range(0, gen_fill[t]);
			return 6'((p > ENTRIES - 1) ? ENTRIES - 1 : p);
		end
		return 6'($urandom_range(0, ENTRIES - 1));
	endfunction

	task automatic queue_item(logic [1:0] f, logic [2:0] sel, logic [63:0] k,
	                          logic [5:0] p, bit drain);
		pend_t it;
		bit seen;
		int t;
		t = int'(sel);
		seen = 1'b0;
		it.req.func      = f;
		it.req.table_sel = sel;
		it.req.key       = k;
		it.req.position  = p;
		it.drain         = drain;
		pending_req = {pending_req, it};
		n_queued++;
		if (f == FUNC_CLEAR) begin
			for (int i = 0; i < TABLES; i++)
				gen_fill[i] = 0;
		end else if (f == FUNC_ADD && t < TABLES) begin
			for (int i = 0; i < gen_fill[t]; i++)
				if (gen_keys[t][i] == k)
					seen = 1'b1;
			if (!seen && gen_fill[t] < ENTRIES) begin
				gen_keys[t][gen_fill[t]] = k;
				gen_fill[t]++;
			end
		end
	endtask

	task automatic queue_fill_run(int t);
		logic [63:0] k;
		queue_item(FUNC_CLEAR, 3'($urandom_range(0, 7)), rand_key(),
		           6'($urandom_range(0, 63)), 1'b1);
		while (gen_fill[t] < ENTRIES) begin
			k = (gen_fill[t] > 0 && $urandom_range(0, 7) == 0) ?
			    gen_keys[t][$urandom_range(0, gen_fill[t] - 1)] : {$urandom, $urandom};
			queue_item(FUNC_ADD, 3'(t), k, 6'($urandom_range(0, 63)), 1'b0);
		end
		repeat (3)
			queue_item(FUNC_ADD, 3'(t), {$urandom, $urandom},
			           6'($urandom_range(0, 63)), 1'b0);
		queue_item(FUNC_ADD, 3'(t), gen_keys[t][ENTRIES - 1], 6'd0, 1'b0);
		queue_item(FUNC_ADD, 3'(t), gen_keys[t][0], 6'd63, 1'b0);
		queue_item(FUNC_GET, 3'(t), rand_key(), 6'd63, 1'b0);
		queue_item(FUNC_GET, 3'(t), rand_key(), 6'd0, 1'b0);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid  <= 1'b0;
			req        <= '0;
			burst_left = $urandom_range(1, 8);
			gap_left   = 0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_rsp = {expected_rsp, intern_predict(req)};
				n_sent++;
			end
			if (!req_valid || !req_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (pending_req.size() == 0 ||
				             (pending_req[0].drain && expected_rsp.size() != 0)) begin
					req_valid <= 1'b0;
				end else begin
					req       <= pending_req[0].req;
					req_valid <= 1'b1;
					pending_req.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						if ($urandom_range(0, 3) == 0) begin
							burst_left = $urandom_range(20, 40);
							gap_left   = 0;
						end else begin
							burst_left = $urandom_range(1, 8);
							gap_left   = ($urandom_range(0, 3) == 0) ?
							             $urandom_range(1, 80) : $urandom_range(1, 6);
						end
					end
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall   <= 1'b0;
			stall_mode  = STALL_NONE;
			mode_left   = 200;
			stall_phase = 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left  = $urandom_range(64, 512);
			end else begin
				mode_left--;
			end
			stall_phase = (stall_phase + 1) % 7;
			case (stall_mode)
				STALL_NONE:  rsp_stall <= 1'b0;
				STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
				default:     rsp_stall <= (stall_phase < 4);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			observed_rsp = {observed_rsp, rsp};
	end

	always @(negedge clk) begin
		rsp_t got;
		rsp_t want;
		while (observed_rsp.size() != 0) begin
			got = observed_rsp.pop_front();
			if (expected_rsp.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected transfer status=%0d slot=%0d key=%h",
					         $realtime, got.status, got.slot, got.stored_key);
			end else begin
				want = expected_rsp.pop_front();
				n_checked++;
				status_seen[want.status]++;
				if (got.status !== want.status || got.slot !== want.slot ||
				    got.stored_key !== want.stored_key) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%0t: result %0d exp status=%0d slot=%0d key=%h",
						         $realtime, n_checked, want.status, want.slot,
						         want.stored_key);
						$display("%0t: result %0d got status=%0d slot=%0d key=%h",
						         $realtime, n_checked, got.status, got.slot,
						         got.stored_key);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
			         cycle_count, expected_rsp.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		int r;
		int t;
		int seq_len;
		int directed_count;
		bit fill_a;
		bit fill_b;
		fill_a = 1'b0;
		fill_b = 1'b0;
		for (int i = 0; i < TABLES; i++)
			gen_fill[i] = 0;

		queue_item(FUNC_GET, 3'd0, '0, 6'd0, 1'b0);
		queue_item(FUNC_ADD, 3'd0, '0, 6'd0, 1'b0);
		queue_item(FUNC_ADD, 3'd0, '1, 6'd63, 1'b0);
		queue_item(FUNC_ADD, 3'd0, '0, 6'd0, 1'b0);
		queue_item(FUNC_GET, 3'd0, '1, 6'd1, 1'b0);
		queue_item(FUNC_GET, 3'd0, '0, 6'd2, 1'b0);
		queue_item(FUNC_GET, 3'd0, '0, 6'd63, 1'b0);
		queue_item(FUNC_ADD, 3'd6, 64'h8000_0000_0000_0001, 6'd0, 1'b0);
		queue_item(FUNC_GET, 3'd6, '0, 6'd0, 1'b0);
		queue_item(FUNC_ADD, SEL_BAD, 64'h0123_4567_89ab_cdef, 6'd0, 1'b0);
		queue_item(FUNC_GET, SEL_BAD, '0, 6'd0, 1'b0);
		queue_item(FUNC_SPARE, 3'd0, '1, 6'd63, 1'b0);
		queue_item(FUNC_SPARE, SEL_BAD, '0, 6'd0, 1'b0);
		queue_item(FUNC_CLEAR, SEL_BAD, '1, 6'd63, 1'b0);
		queue_item(FUNC_GET, 3'd0, '0, 6'd0, 1'b1);
		queue_item(FUNC_ADD, 3'd0, '1, 6'd0, 1'b0);
		queue_item(FUNC_ADD, 3'd3, 64'h5555_5555_5555_5555, 6'd0, 1'b0);
		queue_item(FUNC_ADD, 3'd3, 64'haaaa_aaaa_aaaa_aaaa, 6'd0, 1'b0);
		queue_item(FUNC_GET, 3'd3, '0, 6'd1, 1'b0);
		queue_item(FUNC_ADD, 3'd3, 64'h5555_5555_5555_5555, 6'd0, 1'b0);
		directed_count = n_queued;

		while (n_queued < directed_count + RAND_ITEMS) begin
			if (!fill_a && n_queued > directed_count + 60) begin
				queue_fill_run($urandom_range(0, TABLES - 1));
				fill_a = 1'b1;
			end else if (!fill_b && n_queued > directed_count + 250) begin
				queue_fill_run($urandom_range(0, TABLES - 1));
				fill_b = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 8) begin
				queue_item(FUNC_CLEAR, 3'($urandom_range(0, 7)), rand_key(),
				           6'($urandom_range(0, 63)), $urandom_range(0, 3) == 0);
			end else if (r < 25) begin
				t = $urandom_range(0, 7);
				queue_item(2'($urandom_range(0, 3)), 3'(t), pick_key(t),
				           6'($urandom_range(0, 63)), 1'b0);
			end else begin
				t = $urandom_range(0, TABLES - 1);
				seq_len = $urandom_range(3, 10);
				for (int i = 0; i < seq_len; i++) begin
					if ($urandom_range(0, 9) < 6)
						queue_item(FUNC_ADD, 3'(t), pick_key(t), 6'($urandom_range(0, 63)),
						           i == 0 && $urandom_range(0, 19) == 0);
					else
						queue_item(FUNC_GET, 3'(t), rand_key(), pick_pos(t), 1'b0);
				end
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
			@(posedge clk);
		repeat (2 * ENTRIES + 16) @(posedge clk);

		$display("sent %0d requests (two full-table runs), checked %0d results, %0d mismatches",
		         n_sent, n_checked, mismatch_count);
		$display("added %0d, present %0d, full %0d, bad table %0d, not found %0d, cleared %0d",
		         status_seen[ST_ADDED], status_seen[ST_PRESENT], status_seen[ST_FULL],
		         status_seen[ST_BAD_TABLE], status_seen[ST_NOT_FOUND], status_seen[ST_CLEARED]);
		if (mismatch_count == 0 && expected_rsp.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
